[design/assert_macros.svh]
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a implies condition c in the same cycle.
`define FHD_ASSERT_SAME(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("same-cycle check failed");

// Condition a implies condition c in the following cycle.
`define FHD_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("next-cycle check failed");

`endif

[design/fhd_pkg.sv]
// Types and constants of the flooding discovery node.
`timescale 1ns / 1ps

package fhd_pkg;

   localparam int HOP_W = 7;
   localparam int ID_W  = 6;

   localparam logic [HOP_W-1:0] UNREACHED = 7'd127;
   localparam logic [HOP_W-1:0] CNT_MAX   = 7'd127;

   // request function codes
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_DISC  = 2'd1;
   localparam logic [1:0] FUNC_COMP  = 2'd2;

   // outgoing message codes
   localparam logic CODE_DISC = 1'b0;
   localparam logic CODE_COMP = 1'b1;

   // register indexes
   localparam logic CSR_NODE_COUNT = 1'b0;
   localparam logic CSR_OWN_ID     = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SELF_RD,
      ST_SELF_WR,
      ST_SELF_OUT
   } state_type;

   typedef struct packed {
      logic             done;
      logic [HOP_W-1:0] hop;
   } entry_type;

   typedef struct packed {
      logic [1:0]       func;
      logic [ID_W-1:0]  origin;
      logic [HOP_W-1:0] hop;
      logic [ID_W-1:0]  sender;
   } request_type;

   typedef struct packed {
      logic             code;
      logic [ID_W-1:0]  origin;
      logic [HOP_W-1:0] hop;
      logic [ID_W-1:0]  prev;
   } message_type;

   typedef struct packed {
      logic        wr_en;
      entry_type   wr_data;
      logic        disc_inc;
      logic        comp_inc;
      logic        emit;
      message_type msg;
   } update_type;

endpackage

[design/fhd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps

module fhd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/fhd_upd.sv]
// Entry update and message decision for one request.
`timescale 1ns / 1ps

module fhd_upd (
   input  fhd_pkg::request_type           req,
   input  logic [fhd_pkg::ID_W-1:0]       own_id,
   input  logic [fhd_pkg::HOP_W-1:0]      n,
   input  fhd_pkg::entry_type             entry,
   output fhd_pkg::update_type            upd
);

   logic                       own_in;
   logic                       origin_in;
   logic                       unreached;
   logic [fhd_pkg::HOP_W-1:0]  stored;
   logic [fhd_pkg::HOP_W-1:0]  fwd;

   always_comb begin
      own_in    = {1'b0, own_id} < n;
      origin_in = {1'b0, req.origin} < n;
      unreached = entry.hop >= n;
      // clamp unreached entries to the node count
      stored    = (entry.hop > n) ? n : entry.hop;
      fwd       = req.hop + 7'd1;
      if (fwd > n) begin
         fwd = n;
      end
   end

   always_comb begin
      upd = '0;
      unique case (req.func)
         fhd_pkg::FUNC_START: begin
            upd.emit       = 1'b1;
            upd.msg.code   = fhd_pkg::CODE_DISC;
            upd.msg.origin = own_id;
            upd.msg.hop    = 7'd1;
            upd.msg.prev   = own_id;
            upd.wr_en      = own_in;
            upd.wr_data    = '{done: entry.done, hop: '0};
            upd.disc_inc   = own_in && unreached;
         end
         fhd_pkg::FUNC_DISC: begin
            if (origin_in && (req.hop < stored)) begin
               upd.emit       = 1'b1;
               upd.msg.code   = fhd_pkg::CODE_DISC;
               upd.msg.origin = req.origin;
               upd.msg.hop    = fwd;
               upd.msg.prev   = req.sender;
               upd.wr_en      = 1'b1;
               upd.wr_data    = '{done: entry.done, hop: req.hop};
               upd.disc_inc   = unreached;
            end
         end
         fhd_pkg::FUNC_COMP: begin
            if (origin_in && !entry.done) begin
               upd.emit       = 1'b1;
               upd.msg.code   = fhd_pkg::CODE_COMP;
               upd.msg.origin = req.origin;
               upd.msg.hop    = req.hop;
               upd.msg.prev   = req.sender;
               upd.wr_en      = 1'b1;
               upd.wr_data    = '{done: 1'b1, hop: entry.hop};
               upd.comp_inc   = 1'b1;
            end
         end
         default: begin
            upd = '0;
         end
      endcase
   end

endmodule

[design/flood_hop_discovery_node_top.sv]
// Top level of the flooding hop-count discovery node.
//
//   channel   handshake              payload
//   request   start / busy           req_func, req_origin_id, req_hop, req_cur_sender
//   response  rsp_strobe (no stall)  rsp_out_code .. rsp_all_done
//   csr       csr_valid / csr_ready  csr_index, csr_wdata
//
// A request first reads its table entry, then writes it back.
// The request that first finds every node goes on through ST_SELF_RD and ST_SELF_WR,
// where the own entry is read and written again, and through ST_SELF_OUT when it
// also forwards a message; this happens once after reset.
// Reset is synchronous and clears the table through per-entry valid bits.
// Responses leave through an output register in the cycle after the decision.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module flood_hop_discovery_node_top #(
   parameter int MAX_NODES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_func,
   input  logic [fhd_pkg::ID_W-1:0]      req_origin_id,
   input  logic [fhd_pkg::HOP_W-1:0]     req_hop,
   input  logic [fhd_pkg::ID_W-1:0]      req_cur_sender,
   output logic                          rsp_strobe,
   output logic                          rsp_out_code,
   output logic [fhd_pkg::ID_W-1:0]      rsp_out_origin,
   output logic [fhd_pkg::HOP_W-1:0]     rsp_out_hop,
   output logic [fhd_pkg::ID_W-1:0]      rsp_out_prev_sender,
   output logic                          rsp_last,
   output logic                          rsp_all_done,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [fhd_pkg::HOP_W-1:0]     csr_wdata
);

   localparam int TBL_DEPTH = (MAX_NODES < 64) ? MAX_NODES : 64;
   localparam int AW = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
   localparam logic [fhd_pkg::HOP_W-1:0] NODE_CAP = 7'(TBL_DEPTH);

   fhd_pkg::state_type state_ff, state_in;

   logic [fhd_pkg::HOP_W-1:0] node_count_ff;
   logic [fhd_pkg::ID_W-1:0]  own_id_ff;
   logic [fhd_pkg::HOP_W-1:0] n;

   fhd_pkg::request_type      req_ff;
   logic [AW-1:0]             addr_ff;
   logic [fhd_pkg::HOP_W-1:0] disc_cnt_ff, disc_cnt_in;
   logic [fhd_pkg::HOP_W-1:0] comp_cnt_ff, comp_cnt_in;
   logic                      all_found_ff;
   logic [TBL_DEPTH-1:0]      valid_ff;
   logic                      rd_valid_ff;
   logic                      pend_ff;
   fhd_pkg::message_type      pend_msg_ff;

   logic                      rsp_strobe_ff;
   fhd_pkg::message_type      rsp_msg_ff;
   logic                      rsp_last_ff;
   logic                      rsp_all_done_ff;

   logic                      accept;
   logic [AW-1:0]             req_addr;
   logic [AW-1:0]             own_addr;
   logic [AW-1:0]             rd_addr;
   logic                      rd_in_range;
   fhd_pkg::entry_type        rd_raw;
   fhd_pkg::entry_type        entry;
   fhd_pkg::update_type       upd;
   fhd_pkg::message_type      self_msg;
   logic                      own_in;
   logic                      self_go;
   logic                      self_mark;

   // per-cycle controls from the output block
   logic                      ram_wr;
   logic [AW-1:0]             ram_wr_addr;
   fhd_pkg::entry_type        ram_wr_data;
   logic                      disc_inc;
   logic                      comp_inc;
   logic                      rsp_load;
   fhd_pkg::message_type      rsp_msg;
   logic                      rsp_last_bit;
   logic                      rsp_all_done_bit;
   logic                      pend_load;
   logic                      found_set;

   // effective node count, clamped to 1..table depth
   always_comb begin
      if (node_count_ff == '0) begin
         n = 7'd1;
      end else if (node_count_ff > NODE_CAP) begin
         n = NODE_CAP;
      end else begin
         n = node_count_ff;
      end
   end

   assign accept    = start && !busy;
   assign busy      = (state_ff != fhd_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_addr  = (req_func == fhd_pkg::FUNC_START) ? own_id_ff[AW-1:0]
                                                         : req_origin_id[AW-1:0];
   assign own_addr  = own_id_ff[AW-1:0];
   assign own_in    = {1'b0, own_id_ff} < n;
   assign rd_addr   = (state_ff == fhd_pkg::ST_SELF_RD) ? own_addr : req_addr;
   assign rd_in_range = (int'(rd_addr) < TBL_DEPTH);

   fhd_ram #(
      .WIDTH ($bits(fhd_pkg::entry_type)),
      .DEPTH (TBL_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // entries never written read as unreached and not done
   always_comb begin
      if (rd_valid_ff) begin
         entry = rd_raw;
      end else begin
         entry.done = 1'b0;
         entry.hop  = fhd_pkg::UNREACHED;
      end
   end

   fhd_upd u_upd (
      .req    (req_ff),
      .own_id (own_id_ff),
      .n      (n),
      .entry  (entry),
      .upd    (upd)
   );

   always_comb begin
      disc_cnt_in = disc_cnt_ff;
      if (disc_inc && (disc_cnt_ff != fhd_pkg::CNT_MAX)) begin
         disc_cnt_in = disc_cnt_ff + 7'd1;
      end
      comp_cnt_in = comp_cnt_ff;
      if (comp_inc && (comp_cnt_ff != fhd_pkg::CNT_MAX)) begin
         comp_cnt_in = comp_cnt_ff + 7'd1;
      end
   end

   assign self_go   = !all_found_ff && (disc_cnt_in >= n);
   assign self_mark = own_in && !entry.done;
   assign self_msg  = '{code: fhd_pkg::CODE_COMP, origin: own_id_ff, hop: n,
                        prev: own_id_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fhd_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = fhd_pkg::ST_EXEC;
            end
         end
         fhd_pkg::ST_EXEC: begin
            state_in = self_go ? fhd_pkg::ST_SELF_RD : fhd_pkg::ST_IDLE;
         end
         fhd_pkg::ST_SELF_RD: begin
            state_in = fhd_pkg::ST_SELF_WR;
         end
         fhd_pkg::ST_SELF_WR: begin
            state_in = pend_ff ? fhd_pkg::ST_SELF_OUT : fhd_pkg::ST_IDLE;
         end
         fhd_pkg::ST_SELF_OUT: begin
            state_in = fhd_pkg::ST_IDLE;
         end
         default: begin
            state_in = fhd_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      ram_wr           = 1'b0;
      ram_wr_addr      = addr_ff;
      ram_wr_data      = upd.wr_data;
      disc_inc         = 1'b0;
      comp_inc         = 1'b0;
      rsp_load         = 1'b0;
      rsp_msg          = upd.msg;
      rsp_last_bit     = 1'b1;
      rsp_all_done_bit = (comp_cnt_in >= n);
      pend_load        = 1'b0;
      found_set        = 1'b0;
      unique case (state_ff)
         fhd_pkg::ST_IDLE: begin
         end
         fhd_pkg::ST_EXEC: begin
            ram_wr    = upd.wr_en;
            disc_inc  = upd.disc_inc;
            comp_inc  = upd.comp_inc;
            found_set = self_go;
            pend_load = 1'b1;
            // hold the message while the own completion is still to come
            rsp_load  = upd.emit && !self_go;
         end
         fhd_pkg::ST_SELF_RD: begin
         end
         fhd_pkg::ST_SELF_WR: begin
            ram_wr       = self_mark;
            ram_wr_addr  = own_addr;
            ram_wr_data  = '{done: 1'b1, hop: entry.hop};
            comp_inc     = self_mark;
            rsp_load     = 1'b1;
            rsp_msg      = pend_ff ? pend_msg_ff : self_msg;
            rsp_last_bit = !pend_ff;
         end
         fhd_pkg::ST_SELF_OUT: begin
            rsp_load = 1'b1;
            rsp_msg  = self_msg;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= fhd_pkg::ST_IDLE;
         node_count_ff   <= 7'd64;
         own_id_ff       <= '0;
         disc_cnt_ff     <= '0;
         comp_cnt_ff     <= '0;
         all_found_ff    <= 1'b0;
         valid_ff        <= '0;
         rd_valid_ff     <= 1'b0;
         pend_ff         <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         disc_cnt_ff   <= disc_cnt_in;
         comp_cnt_ff   <= comp_cnt_in;
         rd_valid_ff   <= rd_in_range && valid_ff[rd_addr];
         rsp_strobe_ff <= rsp_load;
         if (found_set) begin
            all_found_ff <= 1'b1;
         end
         if (ram_wr) begin
            valid_ff[ram_wr_addr] <= 1'b1;
         end
         if (pend_load) begin
            pend_ff <= upd.emit;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == fhd_pkg::CSR_NODE_COUNT) begin
               node_count_ff <= csr_wdata;
            end else begin
               own_id_ff <= csr_wdata[fhd_pkg::ID_W-1:0];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff  <= '{func: req_func, origin: req_origin_id, hop: req_hop,
                      sender: req_cur_sender};
         addr_ff <= req_addr;
      end
      if (pend_load) begin
         pend_msg_ff <= upd.msg;
      end
      if (rsp_load) begin
         rsp_msg_ff      <= rsp_msg;
         rsp_last_ff     <= rsp_last_bit;
         rsp_all_done_ff <= rsp_all_done_bit;
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_out_code        = rsp_msg_ff.code;
   assign rsp_out_origin      = rsp_msg_ff.origin;
   assign rsp_out_hop         = rsp_msg_ff.hop;
   assign rsp_out_prev_sender = rsp_msg_ff.prev;
   assign rsp_last            = rsp_last_ff;
   assign rsp_all_done        = rsp_all_done_ff;

   `FHD_ASSERT_NEXT(a_nonfinal_next, clock, reset, rsp_strobe_ff && !rsp_last_ff, rsp_strobe_ff)
   `FHD_ASSERT_NEXT(a_found_sticks, clock, reset, all_found_ff, all_found_ff)
   `FHD_ASSERT_SAME(a_self_needs_found, clock, reset, state_ff == fhd_pkg::ST_SELF_WR, all_found_ff)

endmodule

[verif/testbench.sv]
// Self-checking testbench for the flooding hop-count discovery node.
`timescale 1ns / 1ps

module testbench;

   localparam int NODE_LIMIT = 64;
   localparam logic [fhd_pkg::HOP_W-1:0] NODE_CAP = 7'd64;
   localparam int SETTLE = 8;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 195;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic                     code;
      logic [fhd_pkg::ID_W-1:0]  origin;
      logic [fhd_pkg::HOP_W-1:0] hop;
      logic [fhd_pkg::ID_W-1:0]  prev;
      logic                     last;
      logic                     all_done;
   } msg_type;

   typedef struct {
      bit                        is_cfg;
      logic                      csr_idx;
      logic [fhd_pkg::HOP_W-1:0] wdata;
      logic [1:0]                func;
      logic [fhd_pkg::ID_W-1:0]  origin;
      logic [fhd_pkg::HOP_W-1:0] hop;
      logic [fhd_pkg::ID_W-1:0]  sender;
      bit                        typed;
      int                        nres;
      msg_type                   want;
   } plan_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [1:0]                req_func = '0;
   logic [fhd_pkg::ID_W-1:0]  req_origin_id = '0;
   logic [fhd_pkg::HOP_W-1:0] req_hop = '0;
   logic [fhd_pkg::ID_W-1:0]  req_cur_sender = '0;
   logic                      rsp_strobe;
   logic                      rsp_out_code;
   logic [fhd_pkg::ID_W-1:0]  rsp_out_origin;
   logic [fhd_pkg::HOP_W-1:0] rsp_out_hop;
   logic [fhd_pkg::ID_W-1:0]  rsp_out_prev_sender;
   logic                      rsp_last;
   logic                      rsp_all_done;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic                      csr_index = 1'b0;
   logic [fhd_pkg::HOP_W-1:0] csr_wdata = '0;

   // predictor state
   logic [fhd_pkg::HOP_W-1:0] hop_tab [NODE_LIMIT];
   logic                      done_tab [NODE_LIMIT];
   logic [fhd_pkg::HOP_W-1:0] found_cnt;
   logic [fhd_pkg::HOP_W-1:0] complete_cnt;
   logic                      all_found;
   logic [fhd_pkg::HOP_W-1:0] cfg_nodes;
   logic [fhd_pkg::ID_W-1:0]  cfg_own;

   msg_type outbound_q[$];
   plan_row_type plan[$];
   int errors = 0;
   int requests_sent = 0;
   int responses_seen = 0;
   int reg_writes = 0;
   int stall_cycles = 0;

   flood_hop_discovery_node_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_origin_id(req_origin_id), .req_hop(req_hop),
      .req_cur_sender(req_cur_sender),
      .rsp_strobe(rsp_strobe), .rsp_out_code(rsp_out_code),
      .rsp_out_origin(rsp_out_origin), .rsp_out_hop(rsp_out_hop),
      .rsp_out_prev_sender(rsp_out_prev_sender), .rsp_last(rsp_last),
      .rsp_all_done(rsp_all_done),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void add_row(plan_row_type r);
      plan.insert(plan.size(), r);
   endfunction

   function automatic void queue_msg(msg_type m);
      outbound_q.insert(outbound_q.size(), m);
   endfunction

   function automatic logic [fhd_pkg::HOP_W-1:0] node_total();
      if (cfg_nodes == '0) return 7'd1;
      if (cfg_nodes > NODE_CAP) return NODE_CAP;
      return cfg_nodes;
   endfunction

   function automatic void mark_reached(logic [fhd_pkg::ID_W-1:0] idx,
                                        logic [fhd_pkg::HOP_W-1:0] h,
                                        logic [fhd_pkg::HOP_W-1:0] n);
      if (hop_tab[idx] >= n && h < n && found_cnt < fhd_pkg::CNT_MAX) found_cnt++;
      hop_tab[idx] = h;
   endfunction

   // Work out the outgoing messages for one request and queue them.
   task automatic route_request(input logic [1:0] f, input logic [fhd_pkg::ID_W-1:0] o,
                                input logic [fhd_pkg::HOP_W-1:0] h,
                                input logic [fhd_pkg::ID_W-1:0] s,
                                output int produced);
      msg_type res [2];
      int k;
      logic [fhd_pkg::HOP_W-1:0] n;
      logic [fhd_pkg::HOP_W-1:0] stored;
      logic [fhd_pkg::HOP_W-1:0] fwd;
      k = 0;
      n = node_total();
      case (f)
         fhd_pkg::FUNC_START: begin
            res[k] = '{fhd_pkg::CODE_DISC, cfg_own, 7'd1, cfg_own, 1'b0, 1'b0};
            k++;
            if ({1'b0, cfg_own} < n) mark_reached(cfg_own, '0, n);
         end
         fhd_pkg::FUNC_DISC: begin
            if ({1'b0, o} < n) begin
               stored = (hop_tab[o] > n) ? n : hop_tab[o];
               if (h < stored) begin
                  fwd = h + 7'd1;
                  mark_reached(o, h, n);
                  if (fwd > n) fwd = n;
                  res[k] = '{fhd_pkg::CODE_DISC, o, fwd, s, 1'b0, 1'b0};
                  k++;
               end
            end
         end
         fhd_pkg::FUNC_COMP: begin
            if ({1'b0, o} < n && !done_tab[o]) begin
               done_tab[o] = 1'b1;
               if (complete_cnt < fhd_pkg::CNT_MAX) complete_cnt++;
               res[k] = '{fhd_pkg::CODE_COMP, o, h, s, 1'b0, 1'b0};
               k++;
            end
         end
         default: ;
      endcase
      if (!all_found && found_cnt >= n) begin
         all_found = 1'b1;
         res[k] = '{fhd_pkg::CODE_COMP, cfg_own, n, cfg_own, 1'b0, 1'b0};
         k++;
         if ({1'b0, cfg_own} < n && !done_tab[cfg_own]) begin
            done_tab[cfg_own] = 1'b1;
            if (complete_cnt < fhd_pkg::CNT_MAX) complete_cnt++;
         end
      end
      produced = k;
      for (int i = 0; i < k; i++) begin
         res[i].last = (i == k - 1);
         res[i].all_done = (complete_cnt >= n);
         queue_msg(res[i]);
      end
   endtask

   task automatic send_request(input logic [1:0] f, input logic [fhd_pkg::ID_W-1:0] o,
                               input logic [fhd_pkg::HOP_W-1:0] h,
                               input logic [fhd_pkg::ID_W-1:0] s,
                               output int produced);
      start <= 1'b1;
      req_func <= f;
      req_origin_id <= o;
      req_hop <= h;
      req_cur_sender <= s;
      do @(posedge clock); while (busy);
      route_request(f, o, h, s, produced);
      requests_sent++;
   endtask

   // Hold requests off until the block is quiet, then write one register.
   task automatic write_reg(input logic idx, input logic [fhd_pkg::HOP_W-1:0] data);
      start <= 1'b0;
      while (outbound_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == fhd_pkg::CSR_NODE_COUNT) cfg_nodes = data;
      else cfg_own = data[fhd_pkg::ID_W-1:0];
      reg_writes++;
   endtask

   function automatic plan_row_type req(logic [1:0] f, logic [fhd_pkg::ID_W-1:0] o,
                                        logic [fhd_pkg::HOP_W-1:0] h,
                                        logic [fhd_pkg::ID_W-1:0] s);
      plan_row_type r;
      r = '{default: '0};
      r.func = f;
      r.origin = o;
      r.hop = h;
      r.sender = s;
      return r;
   endfunction

   function automatic plan_row_type chk(logic [1:0] f, logic [fhd_pkg::ID_W-1:0] o,
                                        logic [fhd_pkg::HOP_W-1:0] h,
                                        logic [fhd_pkg::ID_W-1:0] s,
                                        int nres, msg_type want);
      plan_row_type r;
      r = req(f, o, h, s);
      r.typed = 1'b1;
      r.nres = nres;
      r.want = want;
      return r;
   endfunction

   function automatic plan_row_type cfg(logic idx, logic [fhd_pkg::HOP_W-1:0] data);
      plan_row_type r;
      r = '{default: '0};
      r.is_cfg = 1'b1;
      r.csr_idx = idx;
      r.wdata = data;
      return r;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      msg_type want;
      if (!reset && rsp_strobe) begin
         responses_seen++;
         if (outbound_q.size() == 0) begin
            $error("response with none expected: origin %0d hop %0d",
                   rsp_out_origin, rsp_out_hop);
            errors++;
         end else begin
            want = outbound_q.pop_front();
            check_field("out_code", int'(want.code), int'(rsp_out_code));
            check_field("out_origin", int'(want.origin), int'(rsp_out_origin));
            check_field("out_hop", int'(want.hop), int'(rsp_out_hop));
            check_field("out_prev_sender", int'(want.prev), int'(rsp_out_prev_sender));
            check_field("last", int'(want.last), int'(rsp_last));
            check_field("all_done", int'(want.all_done), int'(rsp_all_done));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("** flood_hop_discovery_node_top: FAILED **");
         $finish;
      end
   end

   initial begin
      int phase;
      int kept;
      int produced;
      int roll;
      logic [1:0] f;
      logic [fhd_pkg::ID_W-1:0] o;
      logic [fhd_pkg::ID_W-1:0] s;
      logic [fhd_pkg::HOP_W-1:0] h;
      logic [fhd_pkg::HOP_W-1:0] n;
      logic [fhd_pkg::HOP_W-1:0] stored;
      bit quiet;
      bit drained;

      foreach (hop_tab[i]) hop_tab[i] = fhd_pkg::UNREACHED;
      foreach (done_tab[i]) done_tab[i] = 1'b0;
      found_cnt = '0;
      complete_cnt = '0;
      all_found = 1'b0;
      cfg_nodes = 7'd64;
      cfg_own = '0;

      add_row(chk(fhd_pkg::FUNC_START, 0, 0, 0, 1, '{fhd_pkg::CODE_DISC, 0, 1, 0, 1, 0}));
      add_row(chk(fhd_pkg::FUNC_DISC, 5, 0, 9, 1, '{fhd_pkg::CODE_DISC, 5, 1, 9, 1, 0}));
      add_row(chk(fhd_pkg::FUNC_DISC, 5, 0, 9, 0, '0));
      add_row(chk(fhd_pkg::FUNC_DISC, 63, 127, 0, 0, '0));
      add_row(chk(fhd_pkg::FUNC_DISC, 63, 63, 63, 1,
                  '{fhd_pkg::CODE_DISC, 63, 64, 63, 1, 0}));
      add_row(req(fhd_pkg::FUNC_DISC, 63, 0, 1));
      add_row(chk(fhd_pkg::FUNC_COMP, 7, 100, 63, 1,
                  '{fhd_pkg::CODE_COMP, 7, 100, 63, 1, 0}));
      add_row(chk(fhd_pkg::FUNC_COMP, 7, 0, 0, 0, '0));
      add_row(chk(FUNC_UNUSED, 63, 127, 63, 0, '0));
      add_row(chk(fhd_pkg::FUNC_START, 0, 0, 0, 1, '{fhd_pkg::CODE_DISC, 0, 1, 0, 1, 0}));
      add_row(req(fhd_pkg::FUNC_COMP, 2, 64, 5));
      add_row(cfg(fhd_pkg::CSR_OWN_ID, 63));
      add_row(req(fhd_pkg::FUNC_START, 0, 0, 0));
      // own entry already complete when every node is first found
      add_row(cfg(fhd_pkg::CSR_NODE_COUNT, 4));
      add_row(cfg(fhd_pkg::CSR_OWN_ID, 2));
      add_row(chk(fhd_pkg::FUNC_DISC, 4, 0, 0, 0, '0));
      add_row(chk(fhd_pkg::FUNC_COMP, 60, 0, 0, 0, '0));
      add_row(req(fhd_pkg::FUNC_START, 0, 0, 0));
      // zero node count clamps to one; own id then lies outside the network
      add_row(cfg(fhd_pkg::CSR_NODE_COUNT, 0));
      add_row(cfg(fhd_pkg::CSR_OWN_ID, 63));
      add_row(req(fhd_pkg::FUNC_START, 0, 0, 0));
      add_row(req(fhd_pkg::FUNC_COMP, 0, 127, 63));
      add_row(cfg(fhd_pkg::CSR_NODE_COUNT, 127));
      add_row(cfg(fhd_pkg::CSR_OWN_ID, 0));
      add_row(req(fhd_pkg::FUNC_DISC, 40, 62, 33));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            write_reg(plan[i].csr_idx, plan[i].wdata);
         end else begin
            send_request(plan[i].func, plan[i].origin, plan[i].hop, plan[i].sender,
                         produced);
            if (plan[i].typed) begin
               // replace the predicted messages with the ones read off by hand
               repeat (produced) void'(outbound_q.pop_back());
               if (plan[i].nres == 1) queue_msg(plan[i].want);
            end
         end
      end

      drained = 1'b0;
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(fhd_pkg::CSR_NODE_COUNT, 64);
               write_reg(fhd_pkg::CSR_OWN_ID, 63);
            end
            1: begin
               write_reg(fhd_pkg::CSR_NODE_COUNT, 1);
               write_reg(fhd_pkg::CSR_OWN_ID, 0);
            end
            2: begin
               write_reg(fhd_pkg::CSR_NODE_COUNT, 127);
               write_reg(fhd_pkg::CSR_OWN_ID, 7'($urandom_range(0, 63)));
            end
            3: begin
               write_reg(fhd_pkg::CSR_NODE_COUNT, 0);
               write_reg(fhd_pkg::CSR_OWN_ID, 63);
            end
            4: begin
               write_reg(fhd_pkg::CSR_NODE_COUNT, 7'($urandom_range(2, 63)));
               write_reg(fhd_pkg::CSR_OWN_ID, 7'($urandom_range(0, 63)));
            end
            default: begin
               write_reg(fhd_pkg::CSR_NODE_COUNT, 7'($urandom_range(0, 127)));
               write_reg(fhd_pkg::CSR_OWN_ID, 7'($urandom_range(0, 63)));
            end
         endcase
         n = node_total();
         quiet = (phase == 2);
         kept = 0;
         while (kept < PHASE_ITEMS) begin
            if (!quiet && $urandom_range(0, 99) < 35) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
            if (phase == 4 && kept == 100 && !drained) begin
               // let every outstanding message out before carrying on
               drained = 1'b1;
               start <= 1'b0;
               do @(posedge clock); while (outbound_q.size() != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 10) f = fhd_pkg::FUNC_START;
            else if (roll < 60) f = fhd_pkg::FUNC_DISC;
            else if (roll < 95) f = fhd_pkg::FUNC_COMP;
            else f = FUNC_UNUSED;
            o = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, n - 1)) : 6'($urandom);
            s = 6'($urandom);
            h = 7'($urandom);
            if (f == fhd_pkg::FUNC_DISC) begin
               roll = $urandom_range(0, 99);
               stored = (hop_tab[o] > n) ? n : hop_tab[o];
               if (roll < 50 && stored > 0) h = 7'($urandom_range(0, stored - 1));
               else if (roll < 80) h = 7'($urandom_range(0, n));
            end
            send_request(f, o, h, s, produced);
            if (!((f == fhd_pkg::FUNC_DISC || f == fhd_pkg::FUNC_COMP) && {1'b0, o} >= n))
               kept++;
         end
      end

      start <= 1'b0;
      while (outbound_q.size() != 0) @(posedge clock);
      repeat (2 * SETTLE) @(posedge clock);

      $display("Run covered %0d requests, %0d responses and %0d register writes,",
               requests_sent, responses_seen, reg_writes);
      $display("with node counts from clamped zero to beyond the table limit.");
      if (errors == 0) begin
         $display("** flood_hop_discovery_node_top: PASSED **");
      end else begin
         $display("** flood_hop_discovery_node_top: FAILED **");
      end
      $finish;
   end

endmodule

[flood_hop_discovery_node_top.f]
+incdir+design
design/fhd_pkg.sv
design/fhd_ram.sv
design/fhd_upd.sv
design/flood_hop_discovery_node_top.sv
verif/testbench.sv
